/* hw/rtl/essr_pkg.sv */
package essr_pkg;

  // Field widths
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned WRAP_W   = 16;
  localparam int unsigned GOAL_W   = 32;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned RELOAD_W = 16;
  localparam int unsigned SPEED_W  = 48;
  localparam int unsigned DELTA_W  = 32;
  localparam int unsigned CMP_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GOAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD = 2'd2;

  // Register reset values
  localparam logic [GOAL_W-1:0]   GOAL_RESET   = 32'd196608;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 24'd21005;
  localparam logic [RELOAD_W-1:0] RELOAD_RESET = 16'd65535;

  // Regulator constants
  localparam logic [CNT_W-1:0] WRAP_SPLIT    = 16'd10000;
  localparam logic [CMP_W-1:0] FINE_STEP     = 16'd10;
  localparam logic [CMP_W-1:0] COARSE_STEP   = 16'd100;
  localparam logic [CMP_W-1:0] COMPARE_TOP   = 16'd9999;
  localparam logic [CMP_W-1:0] COMPARE_RESET = 16'd4000;
  localparam logic [CMP_W-1:0] COMPARE_PEAK  = 16'd10008;

  // Event kinds
  localparam logic REQ_OVERFLOW = 1'b0;
  localparam logic REQ_TICK     = 1'b1;

  // Controller states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DELTA  = 2'd1;
  localparam logic [1:0] S_SPEED  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  typedef struct packed {
    logic ld_ovf;
    logic ld_tick;
    logic do_delta;
    logic do_speed;
    logic do_out;
  } essr_cmd_t;

endpackage

/* hw/rtl/essr_if.sv */
interface essr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [essr_pkg::CNT_W-1:0]    counter_value;

  modport source(output valid, req_type, counter_value, input ready);
  modport sink(input valid, req_type, counter_value, output ready);
endinterface

interface essr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [essr_pkg::SPEED_W-1:0]  signed_speed;
  logic signed [essr_pkg::DELTA_W-1:0]  count_delta;
  logic [essr_pkg::CMP_W-1:0]           pwm_compare;
  logic                                 compare_written;

  modport source(output valid, signed_speed, count_delta, pwm_compare, compare_written,
                 input ready);
  modport sink(input valid, signed_speed, count_delta, pwm_compare, compare_written,
               output ready);
endinterface

interface essr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [essr_pkg::CFG_IDX_W-1:0]     index;
  logic [essr_pkg::CFG_DATA_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/encoder_speed_step_regulator_top.sv */
// Encoder speed regulator. Overflow items (req_type 0) adjust the wrap count
// and give no result; the block stays ready for a new item after one. Tick
// items (req_type 1) give one result and pass through four steps from
// acceptance to the result register: the wrap-times-reload product, the
// count delta, the delta-times-scale product, and saturation, comparison
// with the goal and the compare step. The controller takes no new item
// during those steps, and the final step holds while an earlier result is
// still waiting on the output. Configuration writes are always accepted and
// should be made only while the block is idle.
module encoder_speed_step_regulator_top (
  input  logic        clk,
  input  logic        rst_n,
  essr_in_if.sink     in_ch,
  essr_out_if.source  out_ch,
  essr_cfg_if.sink    cfg_ch
);

  essr_pkg::essr_cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  essr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .cmd         (cmd)
  );

  essr_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_counter_value    (in_ch.counter_value),
    .cfg_we              (cfg_ch.valid),
    .cfg_index           (cfg_ch.index),
    .cfg_data            (cfg_ch.data),
    .out_signed_speed    (out_ch.signed_speed),
    .out_count_delta     (out_ch.count_delta),
    .out_pwm_compare     (out_ch.pwm_compare),
    .out_compare_written (out_ch.compare_written)
  );

endmodule

/* hw/rtl/essr_ctrl.sv */
module essr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_req_type,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output essr_pkg::essr_cmd_t cmd
);

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready  = (state_r == essr_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cmd.ld_ovf    = accept && (in_req_type == essr_pkg::REQ_OVERFLOW);
    cmd.ld_tick   = accept && (in_req_type == essr_pkg::REQ_TICK);
    case (state_r)
      essr_pkg::S_IDLE: begin
        if (cmd.ld_tick) state_nxt = essr_pkg::S_DELTA;
      end
      essr_pkg::S_DELTA: begin
        cmd.do_delta = 1'b1;
        state_nxt    = essr_pkg::S_SPEED;
      end
      essr_pkg::S_SPEED: begin
        cmd.do_speed = 1'b1;
        state_nxt    = essr_pkg::S_FINISH;
      end
      essr_pkg::S_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.do_out = 1'b1;
          state_nxt  = essr_pkg::S_IDLE;
        end
      end
      default: state_nxt = essr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.do_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= essr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ld_ovf, cmd.ld_tick, cmd.do_delta, cmd.do_speed, cmd.do_out}))
    else $error("controller issued more than one command");

  a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_tick |-> ##3 (state_r == essr_pkg::S_FINISH))
    else $error("tick item did not reach the finish step in time");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_out |=> out_valid_r)
    else $error("result loaded but not presented");

  a_finish_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == essr_pkg::S_FINISH) && out_valid_r && !out_ready
      |=> (state_r == essr_pkg::S_FINISH))
    else $error("result overwritten while still pending");

endmodule

/* hw/rtl/essr_dp.sv */
module essr_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  essr_pkg::essr_cmd_t                  cmd,
  input  logic [essr_pkg::CNT_W-1:0]           in_counter_value,
  input  logic                                 cfg_we,
  input  logic [essr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [essr_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic signed [essr_pkg::SPEED_W-1:0]  out_signed_speed,
  output logic signed [essr_pkg::DELTA_W-1:0]  out_count_delta,
  output logic [essr_pkg::CMP_W-1:0]           out_pwm_compare,
  output logic                                 out_compare_written
);

  localparam logic signed [34:0] DELTA_MAX = 35'sd2147483647;
  localparam logic signed [34:0] DELTA_MIN = -35'sd2147483648;
  localparam logic signed [56:0] SPEED_MAX = 57'sd140737488355327;
  localparam logic signed [56:0] SPEED_MIN = -57'sd140737488355328;

  logic [essr_pkg::GOAL_W-1:0]        goal_r;
  logic [essr_pkg::SCALE_W-1:0]       scale_r;
  logic [essr_pkg::RELOAD_W-1:0]      reload_r;

  logic signed [essr_pkg::WRAP_W-1:0] wrap_r, wrap_nxt;
  logic signed [33:0]                 last_r;
  logic [essr_pkg::CMP_W-1:0]         cmp_r, cmp_nxt;
  logic                               written_nxt;

  logic [essr_pkg::CNT_W-1:0]         cnt_r;
  logic signed [32:0]                 prod_r;
  logic signed [essr_pkg::DELTA_W-1:0] delta_r, delta_nxt;
  logic signed [56:0]                 sp_raw_r;

  logic signed [33:0]                 total;
  logic signed [34:0]                 diff;
  logic signed [essr_pkg::SPEED_W-1:0] speed;
  logic [essr_pkg::SPEED_W-1:0]       mag;
  logic [essr_pkg::SPEED_W-1:0]       goal_ext;
  logic                               below, above;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r   <= essr_pkg::GOAL_RESET;
      scale_r  <= essr_pkg::SCALE_RESET;
      reload_r <= essr_pkg::RELOAD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        essr_pkg::REG_GOAL:   goal_r   <= cfg_data;
        essr_pkg::REG_SCALE:  scale_r  <= cfg_data[essr_pkg::SCALE_W-1:0];
        essr_pkg::REG_RELOAD: reload_r <= cfg_data[essr_pkg::RELOAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Wrap direction follows the counter position at overflow
  assign wrap_nxt = (in_counter_value < essr_pkg::WRAP_SPLIT) ? wrap_r + 16'sd1
                                                              : wrap_r - 16'sd1;

  assign total = 34'(prod_r) + $signed({18'b0, cnt_r});
  assign diff  = 35'(total) - 35'(last_r);

  always_comb begin
    if (diff > DELTA_MAX)      delta_nxt = DELTA_MAX[31:0];
    else if (diff < DELTA_MIN) delta_nxt = DELTA_MIN[31:0];
    else                       delta_nxt = diff[31:0];
  end

  always_comb begin
    if (sp_raw_r > SPEED_MAX)      speed = SPEED_MAX[47:0];
    else if (sp_raw_r < SPEED_MIN) speed = SPEED_MIN[47:0];
    else                           speed = sp_raw_r[47:0];
  end

  assign mag      = speed[essr_pkg::SPEED_W-1] ? 48'(-speed) : speed;
  assign goal_ext = {16'b0, goal_r};
  assign below    = mag < goal_ext;
  assign above    = mag > goal_ext;

  always_comb begin
    cmp_nxt     = cmp_r;
    written_nxt = 1'b0;
    if (cmp_r != '0 && cmp_r < essr_pkg::COMPARE_TOP) begin
      if (below) begin
        cmp_nxt     = cmp_r + essr_pkg::FINE_STEP;
        written_nxt = 1'b1;
      end else if (above) begin
        // floor at zero rather than wrap
        cmp_nxt     = (cmp_r >= essr_pkg::FINE_STEP) ? cmp_r - essr_pkg::FINE_STEP : '0;
        written_nxt = 1'b1;
      end
    end else if (cmp_r == '0) begin
      cmp_nxt = essr_pkg::COARSE_STEP;
    end else begin
      cmp_nxt = cmp_r - essr_pkg::COARSE_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= '0;
      last_r <= '0;
      cmp_r  <= essr_pkg::COMPARE_RESET;
    end else begin
      if (cmd.ld_ovf)   wrap_r <= wrap_nxt;
      if (cmd.do_delta) last_r <= total;
      if (cmd.do_out)   cmp_r  <= cmp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_tick) begin
      cnt_r  <= in_counter_value;
      prod_r <= wrap_r * $signed({1'b0, reload_r});
    end
    if (cmd.do_delta) delta_r  <= delta_nxt;
    if (cmd.do_speed) sp_raw_r <= delta_r * $signed({1'b0, scale_r});
    if (cmd.do_out) begin
      out_signed_speed    <= speed;
      out_count_delta     <= delta_r;
      out_pwm_compare     <= cmp_nxt;
      out_compare_written <= written_nxt;
    end
  end

  a_cmp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_r <= essr_pkg::COMPARE_PEAK)
    else $error("compare value left its reachable range");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_delta |=> (last_r == $past(total)))
    else $error("previous total not updated on tick");

endmodule
